/* sv/did_pkg.sv */
// ----------------------------------------------------------------------------
// did_pkg
// Shared types and codes for the delta instruction decoder.
// ----------------------------------------------------------------------------
package did_pkg;

	localparam int SIZE_BITS_DEF = 32;
	localparam int RQ_DEPTH      = 4;

	// result kinds
	localparam logic [2:0] KIND_LITERAL = 3'd0;
	localparam logic [2:0] KIND_COPY    = 3'd1;
	localparam logic [2:0] KIND_TARGET  = 3'd2;
	localparam logic [2:0] KIND_END_OK  = 3'd3;
	localparam logic [2:0] KIND_END_ERR = 3'd4;

	// error codes
	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_SRC_SIZE  = 3'd1;
	localparam logic [2:0] ERR_OPCODE0   = 3'd2;
	localparam logic [2:0] ERR_RANGE     = 3'd3;
	localparam logic [2:0] ERR_TRAILING  = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;
	localparam logic [2:0] ERR_TGT_SIZE  = 3'd6;
	localparam logic [2:0] ERR_WIDE      = 3'd7;

	// copy size field of zero stands for this length
	localparam logic [23:0] COPY_SIZE_ZERO = 24'h010000;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  literal;
		logic [31:0] copy_offset;
		logic [31:0] length;
		logic [2:0]  error_code;
		logic        last;
	} res_t;

	// up to two results pushed per decoded byte, r0 first
	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

/* sv/did_intf.sv */
// ----------------------------------------------------------------------------
// did_intf
// Channel interfaces: delta byte input, result output, configuration write.
// ----------------------------------------------------------------------------
interface did_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] delta_byte;
	logic       final_byte;

	modport source (output valid, output delta_byte, output final_byte, input ready);
	modport sink (input valid, input delta_byte, input final_byte, output ready);
endinterface

interface did_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [7:0]  literal;
	logic [31:0] copy_offset;
	logic [31:0] length;
	logic [2:0]  error_code;
	logic        last;

	modport source (output valid, output kind, output literal, output copy_offset,
		output length, output error_code, output last, input ready);
	modport sink (input valid, input kind, input literal, input copy_offset,
		input length, input error_code, input last, output ready);
endinterface

interface did_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] source_length;

	modport source (output valid, output source_length, input ready);
	modport sink (input valid, input source_length, output ready);
endinterface

/* sv/did_core.sv */
// ----------------------------------------------------------------------------
// did_core
// Input register and per-byte decode: headers, copy/insert commands, end status.
// ----------------------------------------------------------------------------
module did_core
	import did_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        in_final,
	input  logic [31:0] src_len,
	input  logic        room,
	output push_t       push
);

	localparam int HDR = (SIZE_BITS < 32) ? SIZE_BITS : 32;
	localparam logic [5:0] HDR_S = 6'(HDR);

	localparam logic [2:0] PH_SRC   = 3'd0;
	localparam logic [2:0] PH_DST   = 3'd1;
	localparam logic [2:0] PH_CMD   = 3'd2;
	localparam logic [2:0] PH_OPS   = 3'd3;
	localparam logic [2:0] PH_INS   = 3'd4;
	localparam logic [2:0] PH_DRAIN = 3'd5;

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        fin_s1;
	logic        advance;

	logic [2:0]     phase_q, n_phase;
	logic [5:0]     shift_q, n_shift;
	logic [HDR-1:0] hacc_q, n_hacc;
	logic [HDR-1:0] tsize_q, n_tsize;
	logic [6:0]     mask_q, n_mask;
	logic [31:0]    poff_q, n_poff;
	logic [23:0]    psz_q, n_psz;
	logic [6:0]     lleft_q, n_lleft;
	logic [31:0]    ocount_q, n_ocount;
	logic [2:0]     err_q, n_err;

	logic [6:0]     p;
	logic [HDR+6:0] sh;
	logic           hdr_ovf;
	logic [HDR-1:0] hacc_add;
	logic [6:0]     sel;
	logic [31:0]    ops_off, cp_off;
	logic [23:0]    ops_psz, cp_psz, cp_size;
	logic           rng_bad, tgt_bad, ins_bad, do_finish;
	logic           body_v;
	res_t           body, fin_res;
	logic [2:0]     end_err;

	assign advance  = vld_s1 && room;
	assign in_ready = !vld_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
			fin_s1  <= in_final;
		end
	end

	// operand byte lands at the lowest mask bit still set
	assign sel = mask_q & (~mask_q + 7'd1);

	always_comb begin
		ops_off = poff_q;
		ops_psz = psz_q;
		for (int k = 0; k < 4; k++) begin
			if (sel[k]) ops_off[8*k +: 8] = byte_s1;
		end
		for (int k = 0; k < 3; k++) begin
			if (sel[4+k]) ops_psz[8*k +: 8] = byte_s1;
		end
	end

	assign p        = byte_s1[6:0];
	assign sh       = {{HDR{1'b0}}, p} << shift_q;
	assign hdr_ovf  = (shift_q >= HDR_S) ? (p != 7'd0) : (sh[HDR+6:HDR] != 7'd0);
	assign hacc_add = hacc_q | ((shift_q >= HDR_S) ? {HDR{1'b0}} : sh[HDR-1:0]);

	assign cp_off  = (phase_q == PH_OPS) ? ops_off : 32'd0;
	assign cp_psz  = (phase_q == PH_OPS) ? ops_psz : 24'd0;
	assign cp_size = (cp_psz == 24'd0) ? COPY_SIZE_ZERO : cp_psz;
	assign rng_bad = ({1'b0, cp_off} + 33'(cp_size)) > {1'b0, src_len};
	assign tgt_bad = ({1'b0, ocount_q} + 33'(cp_size)) > 33'(tsize_q);
	assign ins_bad = ({1'b0, ocount_q} + 33'(byte_s1)) > 33'(tsize_q);

	always_comb begin
		n_phase   = phase_q;
		n_shift   = shift_q;
		n_hacc    = hacc_q;
		n_tsize   = tsize_q;
		n_mask    = mask_q;
		n_poff    = poff_q;
		n_psz     = psz_q;
		n_lleft   = lleft_q;
		n_ocount  = ocount_q;
		n_err     = err_q;
		body_v    = 1'b0;
		body      = '0;
		do_finish = 1'b0;

		case (phase_q)
			PH_SRC, PH_DST: begin
				if (hdr_ovf) begin
					n_phase = PH_DRAIN;
					n_err   = ERR_WIDE;
				end else begin
					n_hacc  = hacc_add;
					n_shift = (shift_q > 6'd56) ? 6'd63 : shift_q + 6'd7;
					if (!byte_s1[7]) begin
						n_shift = 6'd0;
						n_hacc  = {HDR{1'b0}};
						if (phase_q == PH_SRC) begin
							if (32'(hacc_add) != src_len) begin
								n_phase = PH_DRAIN;
								n_err   = ERR_SRC_SIZE;
							end else begin
								n_phase = PH_DST;
							end
						end else begin
							n_tsize     = hacc_add;
							body_v      = 1'b1;
							body.kind   = KIND_TARGET;
							body.length = 32'(hacc_add);
							n_phase     = PH_CMD;
						end
					end
				end
			end
			PH_CMD: begin
				if ({1'b0, ocount_q} >= 33'(tsize_q)) begin
					n_phase = PH_DRAIN;
					n_err   = ERR_TRAILING;
				end else if (byte_s1[7]) begin
					n_mask = byte_s1[6:0];
					n_poff = 32'd0;
					n_psz  = 24'd0;
					if (byte_s1[6:0] == 7'd0) do_finish = 1'b1;
					else n_phase = PH_OPS;
				end else if (byte_s1 != 8'd0) begin
					if (ins_bad) begin
						n_phase = PH_DRAIN;
						n_err   = ERR_TGT_SIZE;
					end else begin
						n_lleft = byte_s1[6:0];
						n_phase = PH_INS;
					end
				end else begin
					n_phase = PH_DRAIN;
					n_err   = ERR_OPCODE0;
				end
			end
			PH_OPS: begin
				n_poff = ops_off;
				n_psz  = ops_psz;
				n_mask = mask_q & (mask_q - 7'd1);
				if ((mask_q & (mask_q - 7'd1)) == 7'd0) do_finish = 1'b1;
			end
			PH_INS: begin
				body_v       = 1'b1;
				body.kind    = KIND_LITERAL;
				body.literal = byte_s1;
				n_ocount     = ocount_q + 32'd1;
				n_lleft      = lleft_q - 7'd1;
				if (lleft_q == 7'd1) n_phase = PH_CMD;
			end
			default: ;
		endcase

		if (do_finish) begin
			if (rng_bad) begin
				n_phase = PH_DRAIN;
				n_err   = ERR_RANGE;
			end else if (tgt_bad) begin
				n_phase = PH_DRAIN;
				n_err   = ERR_TGT_SIZE;
			end else begin
				body_v           = 1'b1;
				body.kind        = KIND_COPY;
				body.copy_offset = cp_off;
				body.length      = 32'(cp_size);
				n_ocount         = ocount_q + 32'(cp_size);
				n_phase          = PH_CMD;
			end
		end
		body.last = !fin_s1;
	end

	// end status looks at the state this byte leaves behind
	always_comb begin
		if (n_phase == PH_DRAIN) end_err = n_err;
		else if (n_phase == PH_CMD) end_err = (n_ocount == 32'(n_tsize)) ? ERR_NONE : ERR_TGT_SIZE;
		else end_err = ERR_TRUNCATED;
		fin_res            = '0;
		fin_res.kind       = (end_err != ERR_NONE) ? KIND_END_ERR : KIND_END_OK;
		fin_res.length     = n_ocount;
		fin_res.error_code = end_err;
		fin_res.last       = 1'b1;
	end

	always_comb begin
		push = '0;
		if (advance) begin
			if (body_v) begin
				push.r0 = body;
				push.r1 = fin_res;
				push.n  = fin_s1 ? 2'd2 : 2'd1;
			end else begin
				push.r0 = fin_res;
				push.n  = fin_s1 ? 2'd1 : 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SRC;
			shift_q  <= '0;
			hacc_q   <= '0;
			tsize_q  <= '0;
			mask_q   <= '0;
			poff_q   <= '0;
			psz_q    <= '0;
			lleft_q  <= '0;
			ocount_q <= '0;
			err_q    <= ERR_NONE;
		end else if (advance) begin
			if (fin_s1) begin
				phase_q  <= PH_SRC;
				shift_q  <= '0;
				hacc_q   <= '0;
				tsize_q  <= '0;
				mask_q   <= '0;
				poff_q   <= '0;
				psz_q    <= '0;
				lleft_q  <= '0;
				ocount_q <= '0;
				err_q    <= ERR_NONE;
			end else begin
				phase_q  <= n_phase;
				shift_q  <= n_shift;
				hacc_q   <= n_hacc;
				tsize_q  <= n_tsize;
				mask_q   <= n_mask;
				poff_q   <= n_poff;
				psz_q    <= n_psz;
				lleft_q  <= n_lleft;
				ocount_q <= n_ocount;
				err_q    <= n_err;
			end
		end
	end

endmodule

/* sv/did_rqueue.sv */
// ----------------------------------------------------------------------------
// did_rqueue
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
module did_rqueue
	import did_pkg::*;
#(
	parameter int DEPTH = RQ_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	output logic  room,
	output logic  out_valid,
	input  logic  out_ready,
	output res_t  head
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	res_t          ent_q [DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;
	logic          pop;

	assign out_valid = (cnt_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = ent_q[rp_q];
	// two free slots needed for a byte that yields a body result and an end status
	assign room      = (cnt_q <= CW'(DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) ent_q[wp_q] <= push.r0;
		if (push.n == 2'd2) ent_q[wp_q + PW'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + PW'(push.n);
			if (pop) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + CW'(push.n) - CW'(pop);
		end
	end

endmodule

/* sv/delta_instruction_decoder_unit.sv */
// ----------------------------------------------------------------------------
// delta_instruction_decoder_unit
// Copy/insert delta decoder, one delta byte per item.
// ----------------------------------------------------------------------------
// Takes one delta byte per cycle. A byte is held in the input register,
// is decoded against the header/command state, and its results (none, one, or
// a body result plus the end status on the final byte) go into a four-entry
// result queue that drains one result per cycle. The input stalls only while
// that queue has fewer than two free entries, so a stream sustains one byte per
// cycle whenever the consumer takes one result per cycle; a final byte that
// also ends a command pushes two results. A byte's results leave through the
// result queue. source_length may be written only while idle.
module delta_instruction_decoder_unit
	import did_pkg::*;
#(
	parameter int SIZE_BITS = SIZE_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	did_in_if.sink       din,
	did_out_if.source    dout,
	did_cfg_if.sink      cfg
);

	logic [31:0] src_len_q;
	logic        room;
	push_t       push;
	res_t        head;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_len_q <= '0;
		end else if (cfg.valid) begin
			src_len_q <= cfg.source_length;
		end
	end

	did_core #(.SIZE_BITS(SIZE_BITS)) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (din.valid),
		.in_ready (din.ready),
		.in_byte  (din.delta_byte),
		.in_final (din.final_byte),
		.src_len  (src_len_q),
		.room     (room),
		.push     (push)
	);

	did_rqueue #(.DEPTH(RQ_DEPTH)) u_rqueue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (dout.valid),
		.out_ready (dout.ready),
		.head      (head)
	);

	assign dout.kind        = head.kind;
	assign dout.literal     = head.literal;
	assign dout.copy_offset = head.copy_offset;
	assign dout.length      = head.length;
	assign dout.error_code  = head.error_code;
	assign dout.last        = head.last;

endmodule

/* sv/did_checker.sv */
// ----------------------------------------------------------------------------
// did_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
module did_checker
	import did_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  kind,
	input logic [7:0]  literal,
	input logic [31:0] copy_offset,
	input logic [31:0] length,
	input logic [2:0]  error_code,
	input logic        last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(length)
			&& $stable(copy_offset) && $stable(last))
		else $error("result changed while stalled");

	a_literal_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_LITERAL |->
			copy_offset == 32'd0 && length == 32'd0 && error_code == ERR_NONE)
		else $error("literal item carries stray fields");

	a_end_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END_OK |-> error_code == ERR_NONE && last)
		else $error("end ok without last or with error code");

	a_end_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_END_ERR |-> error_code != ERR_NONE && last
			&& literal == 8'd0)
		else $error("end error malformed");

	a_body_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_COPY || kind == KIND_TARGET) |-> error_code == ERR_NONE
			&& literal == 8'd0)
		else $error("body item carries error code");

endmodule

bind delta_instruction_decoder_unit did_checker u_did_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (dout.valid),
	.out_ready   (dout.ready),
	.kind        (dout.kind),
	.literal     (dout.literal),
	.copy_offset (dout.copy_offset),
	.length      (dout.length),
	.error_code  (dout.error_code),
	.last        (dout.last)
);

/* test/delta_instruction_decoder_unit_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// delta_instruction_decoder_unit_test
// Self-checking bench for the copy/insert delta decoder. A class-based
// decoder model predicts every result from the accepted bytes and checks the
// result stream in order. Directed corner deltas run first, then random
// deltas, mostly well formed, over several source lengths.
// ----------------------------------------------------------------------------
module delta_instruction_decoder_unit_test;
	import did_pkg::*;

	localparam int ITEMS_TARGET = 750;
	localparam int NUM_PHASES   = 7;
	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 3000;

	typedef enum logic [2:0] {
		PH_SRC, PH_DST, PH_CMD, PH_OPS, PH_INS, PH_DRAIN
	} dec_phase_e;

	class delta_scoreboard;
		logic [31:0] source_length;
		dec_phase_e  phase;
		logic [5:0]  shift_amt;
		logic [31:0] hdr_acc;
		logic [31:0] target_size;
		logic [6:0]  op_mask;
		logic [31:0] copy_off;
		logic [23:0] copy_len;
		logic [6:0]  literals_left;
		logic [32:0] produced;
		logic [2:0]  err_latched;
		res_t        expected_results[$];
		res_t        step_out[$];
		int          mismatches;
		int          results_seen;
		int          ends_ok;
		int          end_errors[8];

		function void clear_decoder();
			phase = PH_SRC;
			shift_amt = '0;
			hdr_acc = '0;
			target_size = '0;
			op_mask = '0;
			copy_off = '0;
			copy_len = '0;
			literals_left = '0;
			produced = '0;
			err_latched = ERR_NONE;
		endfunction

		function void power_on();
			source_length = '0;
			clear_decoder();
		endfunction

		function void emit(logic [2:0] kind, logic [7:0] lit, logic [31:0] off,
			logic [31:0] len, logic [2:0] code);
			res_t r;
			r.kind = kind;
			r.literal = lit;
			r.copy_offset = off;
			r.length = len;
			r.error_code = code;
			r.last = 1'b0;
			step_out.push_back(r);
		endfunction

		function void raise(logic [2:0] code);
			err_latched = code;
			phase = PH_DRAIN;
		endfunction

		function void close_copy();
			logic [63:0] len;
			len = (copy_len != 0) ? 64'(copy_len) : 64'(COPY_SIZE_ZERO);
			if (64'(copy_off) + len > 64'(source_length))
				raise(ERR_RANGE);
			else if (64'(produced) + len > 64'(target_size))
				raise(ERR_TGT_SIZE);
			else begin
				emit(KIND_COPY, 8'd0, copy_off, len[31:0], ERR_NONE);
				produced += len[32:0];
				phase = PH_CMD;
			end
		endfunction

		function void header_step(logic [7:0] b);
			logic [63:0] p;
			p = 64'(b[6:0]);
			if (shift_amt >= 32) begin
				if (p != 0) begin
					raise(ERR_WIDE);
					return;
				end
			end else begin
				if ((p >> (32 - shift_amt)) != 0) begin
					raise(ERR_WIDE);
					return;
				end
				hdr_acc |= 32'(p << shift_amt);
			end
			// shift saturates at 63 on long zero-padded headers
			shift_amt = (shift_amt > 56) ? 6'd63 : shift_amt + 6'd7;
			if (b[7])
				return;
			if (phase == PH_SRC) begin
				if (hdr_acc != source_length) begin
					raise(ERR_SRC_SIZE);
					return;
				end
				phase = PH_DST;
			end else begin
				target_size = hdr_acc;
				emit(KIND_TARGET, 8'd0, 32'd0, hdr_acc, ERR_NONE);
				phase = PH_CMD;
			end
			shift_amt = '0;
			hdr_acc = '0;
		endfunction

		// returns 1 when the byte was decoded rather than dropped after an error
		function bit note_byte(logic [7:0] b, logic fin);
			logic [2:0] code;
			bit         used;
			int         idx;
			res_t       r;
			used = (phase != PH_DRAIN);
			step_out.delete();
			case (phase)
				PH_SRC, PH_DST: header_step(b);
				PH_CMD: begin
					if (64'(produced) >= 64'(target_size))
						raise(ERR_TRAILING);
					else if (b[7]) begin
						op_mask = b[6:0];
						copy_off = '0;
						copy_len = '0;
						if (op_mask == 0)
							close_copy();
						else
							phase = PH_OPS;
					end else if (b != 0) begin
						if (64'(produced) + 64'(b) > 64'(target_size))
							raise(ERR_TGT_SIZE);
						else begin
							literals_left = b[6:0];
							phase = PH_INS;
						end
					end else
						raise(ERR_OPCODE0);
				end
				PH_OPS: begin
					// operand bytes arrive in mask-bit order, lowest first
					idx = 0;
					while (idx < 6 && !op_mask[idx])
						idx++;
					if (idx < 4)
						copy_off |= 32'(b) << (8 * idx);
					else
						copy_len |= 24'(b) << (8 * (idx - 4));
					op_mask = op_mask & (op_mask - 7'd1);
					if (op_mask == 0)
						close_copy();
				end
				PH_INS: begin
					emit(KIND_LITERAL, b, 32'd0, 32'd0, ERR_NONE);
					produced += 33'd1;
					literals_left = literals_left - 7'd1;
					if (literals_left == 0)
						phase = PH_CMD;
				end
				default: ;
			endcase
			if (fin) begin
				if (phase == PH_DRAIN)
					code = err_latched;
				else if (phase == PH_CMD)
					code = (produced == 33'(target_size)) ? ERR_NONE : ERR_TGT_SIZE;
				else
					code = ERR_TRUNCATED;
				emit((code != ERR_NONE) ? KIND_END_ERR : KIND_END_OK, 8'd0, 32'd0,
					produced[31:0], code);
				if (code == ERR_NONE)
					ends_ok++;
				else
					end_errors[code]++;
				clear_decoder();
			end
			if (step_out.size() > 0) begin
				r = step_out.pop_back();
				r.last = 1'b1;
				step_out.push_back(r);
			end
			foreach (step_out[i])
				expected_results.push_back(step_out[i]);
			return used;
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
				mismatches++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual kind %0d length %h",
					$time, got.kind, got.length);
				mismatches++;
				return;
			end
			want = expected_results.pop_front();
			results_seen++;
			compare_field("kind", 32'(want.kind), 32'(got.kind));
			compare_field("literal", 32'(want.literal), 32'(got.literal));
			compare_field("copy_offset", want.copy_offset, got.copy_offset);
			compare_field("length", want.length, got.length);
			compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
			compare_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	did_in_if  din_ch ();
	did_out_if dout_ch ();
	did_cfg_if cfg_ch ();

	delta_instruction_decoder_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_ch),
		.dout   (dout_ch),
		.cfg    (cfg_ch)
	);

	delta_scoreboard sb = new();
	logic [7:0]      stream[$];
	bit              calm = 1'b0;
	int              hold_cycles = 0;
	int              items_used = 0;
	int              deltas_sent = 0;
	int              idle_cycles = 0;

	always #5 clk = ~clk;

	// result consumer: random stall bursts, one long hold-off on request
	initial begin
		dout_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				dout_ch.ready = 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				dout_ch.ready = 1'b0;
				repeat ($urandom_range(0, 12)) @(negedge clk);
			end else
				dout_ch.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1)
			sb.check_result({dout_ch.kind, dout_ch.literal, dout_ch.copy_offset,
				dout_ch.length, dout_ch.error_code, dout_ch.last});
	end

	always @(posedge clk) begin
		if ((din_ch.valid === 1'b1 && din_ch.ready === 1'b1) ||
			(dout_ch.valid === 1'b1 && dout_ch.ready === 1'b1) ||
			(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog: no handshake for %0d cycles, %0d results outstanding",
				$time, idle_cycles, sb.expected_results.size());
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		@(negedge clk);
		if (!calm && $urandom_range(0, 5) == 0) begin
			din_ch.valid = 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		din_ch.valid = 1'b1;
		din_ch.delta_byte = b;
		din_ch.final_byte = fin;
		do @(posedge clk); while (din_ch.ready !== 1'b1);
		void'(sb.note_byte(b, fin));
		items_used++;
	endtask

	task automatic send_stream();
		foreach (stream[i])
			send_byte(stream[i], i == stream.size() - 1);
		stream.delete();
		deltas_sent++;
	endtask

	// drop valid, let all results drain, then give the pipe time to empty
	task automatic wait_quiet();
		@(negedge clk);
		din_ch.valid = 1'b0;
		while (sb.expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_source_length(input logic [31:0] v);
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.source_length = v;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		sb.source_length = v;
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// little-endian base-128, optionally padded with redundant zero groups
	function automatic void put_varint(logic [63:0] v, int pad);
		logic [7:0] b;
		while (1) begin
			b = {1'b0, v[6:0]};
			v = v >> 7;
			if (v == 0 && pad == 0) begin
				stream.push_back(b);
				break;
			end
			if (v == 0)
				pad--;
			stream.push_back(b | 8'h80);
		end
	endfunction

	function automatic int header_pad();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 9) : 0;
	endfunction

	function automatic void build_delta(logic [31:0] slen, logic [63:0] src_hdr,
		int tgt_adj, bit wide);
		logic [7:0]  body[$];
		logic [7:0]  ops[$];
		logic [7:0]  byte_val;
		logic [31:0] sz;
		logic [31:0] off;
		logic [23:0] field;
		logic [6:0]  mask;
		logic [63:0] declared;
		longint      total;
		int          ncmd;
		int          n;
		total = 0;
		ncmd = $urandom_range(0, 6);
		repeat (ncmd) begin
			if (slen == 0 || $urandom_range(0, 1) == 0) begin
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 4);
				body.push_back(8'(n));
				repeat (n) body.push_back(8'($urandom_range(0, 255)));
				total += n;
			end else begin
				case ($urandom_range(0, 2))
					0: sz = $urandom_range(1, 16);
					1: sz = 32'h10000;
					default: sz = $urandom_range(1, 24'hFFFFFF);
				endcase
				if (sz > slen)
					sz = $urandom_range(1, (slen > 32'hFFFFFF) ? 32'hFFFFFF : slen);
				off = ($urandom_range(0, 3) == 0) ? slen - sz : $urandom_range(0, slen - sz);
				// 64 KiB may go as an empty size field or spelled out
				field = (sz == 32'h10000 && $urandom_range(0, 1) == 1) ? 24'd0 : sz[23:0];
				mask = '0;
				ops.delete();
				for (int i = 0; i < 7; i++) begin
					byte_val = (i < 4) ? off[8 * i +: 8] : field[8 * (i - 4) +: 8];
					if (byte_val != 0 || $urandom_range(0, 5) == 0) begin
						mask[i] = 1'b1;
						ops.push_back(byte_val);
					end
				end
				body.push_back({1'b1, mask});
				foreach (ops[k])
					body.push_back(ops[k]);
				total += sz;
			end
		end
		total += tgt_adj;
		if (total < 0)
			total = 0;
		declared = 64'(total);
		if (wide)
			declared[63:32] = $urandom_range(1, 32'hFFFFFFFF);
		put_varint(src_hdr, header_pad());
		put_varint(declared, header_pad());
		foreach (body[k])
			stream.push_back(body[k]);
	endfunction

	task automatic random_delta(input logic [31:0] slen);
		int          pick;
		int          tgt_adj;
		bit          wide;
		logic [63:0] src_hdr;
		pick = $urandom_range(0, 99);
		tgt_adj = 0;
		wide = 1'b0;
		src_hdr = 64'(slen);
		stream.delete();
		if (pick < 10) begin
			repeat ($urandom_range(1, 8)) stream.push_back(8'($urandom_range(0, 255)));
		end else begin
			if (pick < 16) begin
				if ($urandom_range(0, 1) == 1)
					src_hdr = 64'(slen ^ $urandom_range(1, 32'hFFFFFFFF));
				else
					src_hdr[63:32] = $urandom_range(1, 255);
			end else if (pick < 24)
				tgt_adj = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 3) : -$urandom_range(1, 3);
			else if (pick < 27)
				wide = 1'b1;
			build_delta(slen, src_hdr, tgt_adj, wide);
			if (pick >= 27 && pick < 40) begin
				case ($urandom_range(0, 2))
					0: if (stream.size() > 1)
						repeat ($urandom_range(1, stream.size() - 1)) void'(stream.pop_back());
					1: repeat ($urandom_range(1, 3)) stream.push_back(8'($urandom_range(0, 255)));
					default: stream[$urandom_range(0, stream.size() - 1)] = 8'($urandom_range(0, 255));
				endcase
			end
		end
		send_stream();
	endtask

	initial begin
		logic [31:0] phase_len[NUM_PHASES];
		int          budget;
		din_ch.valid = 1'b0;
		din_ch.delta_byte = 8'd0;
		din_ch.final_byte = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.source_length = 32'd0;
		sb.power_on();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corners, source length still at its reset value of zero
		stream = '{8'h01};                               // source size mismatch
		send_stream();
		stream = '{8'h80};                               // ends inside a header
		send_stream();
		stream = '{8'h00, 8'h05, 8'h00};                 // zero opcode
		send_stream();
		stream = '{8'h00, 8'h00, 8'h01};                 // command after target reached
		send_stream();
		stream = '{8'h00, 8'h01, 8'h90, 8'h05};          // copy past end of source
		send_stream();
		stream = '{8'h00, 8'h04, 8'h01, 8'h07};          // ends short of target
		send_stream();
		stream = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h10};   // header wider than 32 bits
		send_stream();
		wait_quiet();
		write_source_length(32'hFFFFFFFF);
		// full-width source header, empty copy opcode means offset 0, 64 KiB
		stream = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F, 8'h80, 8'h80, 8'h04, 8'h80};
		send_stream();

		phase_len = '{32'hFFFFFFFF, 32'd0, $urandom, 32'd1, 32'h00010000,
			$urandom_range(2, 4096), 32'hFFFFFFFF};
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_quiet();
			write_source_length(phase_len[ph]);
			if (ph == NUM_PHASES - 1)
				calm = 1'b1;
			if (ph == 2)
				hold_cycles = HOLD_CYCLES;
			budget = items_used + ITEMS_TARGET / NUM_PHASES;
			while (items_used < budget)
				random_delta(phase_len[ph]);
		end

		wait_quiet();
		repeat (6) @(posedge clk);
		$display("run: %0d deltas, %0d bytes sent, %0d results checked, %0d mismatches",
			deltas_sent, items_used, sb.results_seen, sb.mismatches);
		$display("run: %0d clean ends; error ends by code 1-7: %0d %0d %0d %0d %0d %0d %0d",
			sb.ends_ok, sb.end_errors[1], sb.end_errors[2], sb.end_errors[3],
			sb.end_errors[4], sb.end_errors[5], sb.end_errors[6], sb.end_errors[7]);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
